// File: hdl/prae_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prae_pkg
// Shared constants and the arctangent table of the pixel ray angle pipeline.
// ----------------------------------------------------------------------------
package prae_pkg;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] REG_FOCAL_X = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_FOCAL_Y = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_CENTER_X = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_CENTER_Y = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_INTR_VALID = 3'd4;

    localparam int InW = 200;
    localparam int OutW = 32;
    localparam int CordicSteps = 20;
    localparam int QuoW = 40;

    localparam logic signed [23:0] PI_Q20 = 24'sd3294199;
    localparam logic signed [15:0] AZ_LIMIT = 16'sd25736;
    localparam logic signed [15:0] EL_LIMIT = 16'sd12868;
    localparam logic [127:0] MAG2_MIN = 128'd18446745;
    localparam logic [63:0] MAG_SMALL = 64'd4295;

    function automatic logic signed [23:0] atan_entry(input logic [4:0] i);
        logic signed [23:0] r;
        case (i)
            5'd0: r = 24'sd823550;
            5'd1: r = 24'sd486170;
            5'd2: r = 24'sd256879;
            5'd3: r = 24'sd130396;
            5'd4: r = 24'sd65451;
            5'd5: r = 24'sd32757;
            5'd6: r = 24'sd16383;
            5'd7: r = 24'sd8192;
            5'd8: r = 24'sd4096;
            5'd9: r = 24'sd2048;
            5'd10: r = 24'sd1024;
            5'd11: r = 24'sd512;
            5'd12: r = 24'sd256;
            5'd13: r = 24'sd128;
            5'd14: r = 24'sd64;
            5'd15: r = 24'sd32;
            5'd16: r = 24'sd16;
            5'd17: r = 24'sd8;
            5'd18: r = 24'sd4;
            5'd19: r = 24'sd2;
            default: r = 24'sd0;
        endcase
        return r;
    endfunction

    // floor shift toward minus infinity
    function automatic logic signed [33:0] asr34(input logic signed [33:0] v,
                                                  input logic [4:0] s);
        return v >>> s;
    endfunction

endpackage
`default_nettype wire

// File: hdl/pixel_ray_azimuth_elevation.sv
`default_nettype none
// Pipeline: 99 register stages, 1 (capture) + 40 (dividers) + 5 (rotate, scale,
//   square) + 32 (square root) + 20 (CORDIC) + 1 (round and output).
// Throughput: one item per cycle while the output is not stalled; each stage is a
//   register with a valid bit, and the whole pipe advances whenever the output register can take data.
// Reset: aresetn synchronous active low clears the valid bits and the configuration registers.
// ----------------------------------------------------------------------------
// pixel_ray_azimuth_elevation
// Back-projects a normalized point to a world ray and gives azimuth/elevation.
// ----------------------------------------------------------------------------
module pixel_ray_azimuth_elevation (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_we,
    input  wire [prae_pkg::CfgIdxW-1:0]  cfg_idx,
    input  wire [prae_pkg::CfgDataW-1:0] cfg_data,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // x_norm[16:0], y_norm[33:17], rot_00..rot_22 18 bits each from [51:34]
    input  wire [prae_pkg::InW-1:0]      s_tdata,
    input  wire                          s_tlast,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // azimuth[15:0], elevation[30:16], angle_valid[31]
    output logic [prae_pkg::OutW-1:0]    m_tdata,
    output logic                         m_tlast
);
    import prae_pkg::*;

    localparam int SqSt = 33;

    logic [15:0] fx_reg, fy_reg, cx_reg, cy_reg;
    logic        iv_reg;
    logic        adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fx_reg <= '0; fy_reg <= '0; cx_reg <= '0; cy_reg <= '0; iv_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_FOCAL_X: fx_reg <= cfg_data;
                REG_FOCAL_Y: fy_reg <= cfg_data;
                REG_CENTER_X: cx_reg <= cfg_data;
                REG_CENTER_Y: cy_reg <= cfg_data;
                REG_INTR_VALID: iv_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---------------- stage 0: numerators
    logic               v0_reg, l0_reg;
    logic [39:0]        nx0_reg, ny0_reg;
    logic               sx0_reg, sy0_reg;
    logic signed [17:0] r0_reg [0:8];
    logic signed [41:0] tx, ty;
    always_comb begin
        tx = ($signed({25'd0, s_tdata[16:0]}) * 42'sd320
              - $signed({14'd0, cx_reg, 12'd0})) * 42'sd16;
        ty = ($signed({25'd0, s_tdata[33:17]}) * 42'sd240
              - $signed({14'd0, cy_reg, 12'd0})) * 42'sd16;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v0_reg <= 1'b0;
        else if (adv) v0_reg <= s_tvalid && iv_reg && fx_reg != 16'd0 && fy_reg != 16'd0;
        if (adv) begin
            l0_reg <= s_tlast;
            sx0_reg <= tx[41];
            sy0_reg <= ty[41];
            nx0_reg <= tx[41] ? 40'(-tx) : tx[39:0];
            ny0_reg <= ty[41] ? 40'(-ty) : ty[39:0];
            for (int i = 0; i < 9; i++) r0_reg[i] <= $signed(s_tdata[34+18*i +: 18]);
        end
    end

    // ---------------- restoring dividers, one quotient bit per stage
    logic               dv [0:QuoW];
    logic               dl [0:QuoW];
    logic [39:0]        dqx [0:QuoW], dqy [0:QuoW];
    logic [16:0]        drx [0:QuoW], dry [0:QuoW];
    logic               dsx [0:QuoW], dsy [0:QuoW];
    logic signed [17:0] drot [0:QuoW][0:8];
    always_comb begin
        dv[0] = v0_reg; dl[0] = l0_reg; dqx[0] = nx0_reg; dqy[0] = ny0_reg;
        drx[0] = '0; dry[0] = '0; dsx[0] = sx0_reg; dsy[0] = sy0_reg;
        for (int i = 0; i < 9; i++) drot[0][i] = r0_reg[i];
    end
    for (genvar k = 0; k < QuoW; k++) begin : g_div
        logic [16:0] ax, ay;
        logic               v_reg, l_reg, sx_reg, sy_reg;
        logic [39:0]        qx_reg, qy_reg;
        logic [16:0]        rx_reg, ry_reg;
        logic signed [17:0] rt_reg [0:8];
        always_comb begin
            ax = {drx[k][15:0], dqx[k][39]};
            ay = {dry[k][15:0], dqy[k][39]};
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) v_reg <= 1'b0;
            else if (adv) v_reg <= dv[k];
            if (adv) begin
                l_reg <= dl[k]; sx_reg <= dsx[k]; sy_reg <= dsy[k];
                rt_reg <= drot[k];
                if (ax >= {1'b0, fx_reg}) begin
                    rx_reg <= ax - {1'b0, fx_reg}; qx_reg <= {dqx[k][38:0], 1'b1};
                end else begin
                    rx_reg <= ax; qx_reg <= {dqx[k][38:0], 1'b0};
                end
                if (ay >= {1'b0, fy_reg}) begin
                    ry_reg <= ay - {1'b0, fy_reg}; qy_reg <= {dqy[k][38:0], 1'b1};
                end else begin
                    ry_reg <= ay; qy_reg <= {dqy[k][38:0], 1'b0};
                end
            end
        end
        always_comb begin
            dv[k+1] = v_reg; dl[k+1] = l_reg; dqx[k+1] = qx_reg; dqy[k+1] = qy_reg;
            drx[k+1] = rx_reg; dry[k+1] = ry_reg; dsx[k+1] = sx_reg; dsy[k+1] = sy_reg;
            drot[k+1] = rt_reg;
        end
    end

    // ---------------- products: w = rot*[65536, -rx, -ry]
    // ray = -signed quotient; |q| < 2^32 fits 33 bits
    logic signed [32:0] rayx, rayy;
    always_comb begin
        rayx = dsx[QuoW] ? $signed({1'b0, dqx[QuoW][31:0]}) : -$signed({1'b0, dqx[QuoW][31:0]});
        rayy = dsy[QuoW] ? $signed({1'b0, dqy[QuoW][31:0]}) : -$signed({1'b0, dqy[QuoW][31:0]});
    end
    logic               v1_reg, l1_reg;
    logic signed [51:0] p1_reg [0:8];
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= dv[QuoW];
        if (adv) begin
            l1_reg <= dl[QuoW];
            for (int i = 0; i < 3; i++) begin
                p1_reg[3*i] <= 52'($signed(drot[QuoW][3*i]) * 52'sd65536);
                p1_reg[3*i+1] <= 52'(drot[QuoW][3*i+1] * rayx);
                p1_reg[3*i+2] <= 52'(drot[QuoW][3*i+2] * rayy);
            end
        end
    end

    logic               v2_reg, l2_reg;
    logic signed [51:0] w2_reg [0:2];
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
        if (adv) begin
            l2_reg <= l1_reg;
            for (int i = 0; i < 3; i++)
                w2_reg[i] <= p1_reg[3*i] + p1_reg[3*i+1] + p1_reg[3*i+2];
        end
    end

    // max magnitude, shift amount, small-vector check
    logic [51:0] m2 [0:2];
    logic [51:0] mx2;
    logic [4:0]  sh;
    always_comb begin
        for (int i = 0; i < 3; i++) m2[i] = w2_reg[i][51] ? 52'(-w2_reg[i]) : w2_reg[i];
        mx2 = m2[0];
        if (m2[1] > mx2) mx2 = m2[1];
        if (m2[2] > mx2) mx2 = m2[2];
        sh = '0;
        for (int b = 30; b < 52; b++) if (mx2[b]) sh = 5'(b - 29);
    end
    logic               v3_reg, l3_reg, big3_reg;
    logic [4:0]         sh3_reg;
    logic [12:0]        sm3_reg [0:2];
    logic signed [51:0] w3_reg [0:2];
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (adv) v3_reg <= v2_reg;
        if (adv) begin
            l3_reg <= l2_reg; sh3_reg <= sh; w3_reg <= w2_reg;
            big3_reg <= 64'(mx2) >= MAG_SMALL;
            for (int i = 0; i < 3; i++) sm3_reg[i] <= m2[i][12:0];
        end
    end

    logic               v4_reg, l4_reg, ok4_reg;
    logic signed [31:0] e4_reg, n4_reg, u4_reg;
    logic [27:0]        s2;
    always_comb begin
        s2 = 28'(sm3_reg[0] * sm3_reg[0]) + 28'(sm3_reg[1] * sm3_reg[1])
             + 28'(sm3_reg[2] * sm3_reg[2]);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (adv) v4_reg <= v3_reg;
        if (adv) begin
            l4_reg <= l3_reg;
            ok4_reg <= big3_reg || 128'(s2) >= MAG2_MIN;
            e4_reg <= 32'(w3_reg[0] >>> sh3_reg);
            n4_reg <= 32'(w3_reg[1] >>> sh3_reg);
            u4_reg <= 32'(w3_reg[2] >>> sh3_reg);
        end
    end

    logic [61:0] hs2;
    logic [30:0] ae, an;
    always_comb begin
        ae = e4_reg[31] ? 31'(-e4_reg) : e4_reg[30:0];
        an = n4_reg[31] ? 31'(-n4_reg) : n4_reg[30:0];
    end
    logic               v5_reg, l5_reg, ok5_reg;
    logic signed [31:0] e5_reg, n5_reg, u5_reg;
    logic [61:0]        ee5_reg, nn5_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (adv) v5_reg <= v4_reg;
        if (adv) begin
            l5_reg <= l4_reg; ok5_reg <= ok4_reg;
            e5_reg <= e4_reg; n5_reg <= n4_reg; u5_reg <= u4_reg;
            ee5_reg <= ae * ae; nn5_reg <= an * an;
        end
    end
    assign hs2 = ee5_reg + nn5_reg;

    // ---------------- square root, one result bit per stage
    logic               qv [0:SqSt-1];
    logic               ql [0:SqSt-1], qok [0:SqSt-1];
    logic signed [31:0] qe [0:SqSt-1], qn [0:SqSt-1], qu [0:SqSt-1];
    logic [63:0]        qrem [0:SqSt-1];
    logic [63:0]        qroot [0:SqSt-1];
    always_comb begin
        qv[0] = v5_reg; ql[0] = l5_reg; qok[0] = ok5_reg;
        qe[0] = e5_reg; qn[0] = n5_reg; qu[0] = u5_reg;
        qrem[0] = {2'b0, hs2}; qroot[0] = '0;
    end
    for (genvar k = 0; k < SqSt - 1; k++) begin : g_sqrt
        localparam int B = 31 - k;
        logic [63:0] trial;
        logic               v_reg, l_reg, ok_reg;
        logic signed [31:0] e_reg, n_reg, u_reg;
        logic [63:0]        rem_reg;
        logic [63:0]        root_reg;
        always_comb trial = qroot[k] + (64'd1 << (2*B));
        always_ff @(posedge aclk) begin
            if (!aresetn) v_reg <= 1'b0;
            else if (adv) v_reg <= qv[k];
            if (adv) begin
                l_reg <= ql[k]; ok_reg <= qok[k];
                e_reg <= qe[k]; n_reg <= qn[k]; u_reg <= qu[k];
                if (qrem[k] >= trial) begin
                    rem_reg <= qrem[k] - trial;
                    root_reg <= (qroot[k] >> 1) + (64'd1 << (2*B));
                end else begin
                    rem_reg <= qrem[k];
                    root_reg <= qroot[k] >> 1;
                end
            end
        end
        always_comb begin
            qv[k+1] = v_reg; ql[k+1] = l_reg; qok[k+1] = ok_reg;
            qe[k+1] = e_reg; qn[k+1] = n_reg; qu[k+1] = u_reg;
            qrem[k+1] = rem_reg; qroot[k+1] = root_reg;
        end
    end

    // ---------------- two CORDIC vectoring lanes
    logic               cv [0:CordicSteps];
    logic               cl [0:CordicSteps], cok [0:CordicSteps];
    logic               azz [0:CordicSteps], elz [0:CordicSteps];
    logic signed [23:0] azb [0:CordicSteps];
    logic signed [33:0] ax_ [0:CordicSteps], ay_ [0:CordicSteps];
    logic signed [33:0] bx_ [0:CordicSteps], by_ [0:CordicSteps];
    logic signed [23:0] az_ [0:CordicSteps], bz_ [0:CordicSteps];
    logic signed [33:0] e0, n0, u0, h0;
    always_comb begin
        e0 = 34'(qe[SqSt-1]); n0 = 34'(qn[SqSt-1]); u0 = 34'(qu[SqSt-1]);
        h0 = $signed({2'b0, qroot[SqSt-1][31:0]});
        cv[0] = qv[SqSt-1]; cl[0] = ql[SqSt-1]; cok[0] = qok[SqSt-1];
        azz[0] = (n0 == 0); elz[0] = (u0 == 0);
        azb[0] = (n0 == 0) ? ((e0 < 0) ? PI_Q20 : 24'sd0)
                 : (e0 < 0) ? ((n0 > 0) ? PI_Q20 : -PI_Q20) : 24'sd0;
        ax_[0] = (e0 < 0) ? -e0 : e0; ay_[0] = (e0 < 0) ? -n0 : n0;
        bx_[0] = h0; by_[0] = u0;
        az_[0] = '0; bz_[0] = '0;
    end
    for (genvar k = 0; k < CordicSteps; k++) begin : g_cordic
        logic signed [33:0] axs, ays, bxs, bys;
        logic signed [23:0] at;
        logic               v_reg, l_reg, ok_reg, azz_reg, elz_reg;
        logic signed [23:0] azb_reg, az_reg, bz_reg;
        logic signed [33:0] ax_reg, ay_reg, bx_reg, by_reg;
        always_comb begin
            axs = asr34(ax_[k], 5'(k)); ays = asr34(ay_[k], 5'(k));
            bxs = asr34(bx_[k], 5'(k)); bys = asr34(by_[k], 5'(k));
            at = atan_entry(5'(k));
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) v_reg <= 1'b0;
            else if (adv) v_reg <= cv[k];
            if (adv) begin
                l_reg <= cl[k]; ok_reg <= cok[k]; azz_reg <= azz[k]; elz_reg <= elz[k];
                azb_reg <= azb[k];
                if (ay_[k] > 0) begin
                    ax_reg <= ax_[k] + ays; ay_reg <= ay_[k] - axs; az_reg <= az_[k] + at;
                end else begin
                    ax_reg <= ax_[k] - ays; ay_reg <= ay_[k] + axs; az_reg <= az_[k] - at;
                end
                if (by_[k] > 0) begin
                    bx_reg <= bx_[k] + bys; by_reg <= by_[k] - bxs; bz_reg <= bz_[k] + at;
                end else begin
                    bx_reg <= bx_[k] - bys; by_reg <= by_[k] + bxs; bz_reg <= bz_[k] - at;
                end
            end
        end
        always_comb begin
            cv[k+1] = v_reg; cl[k+1] = l_reg; cok[k+1] = ok_reg;
            azz[k+1] = azz_reg; elz[k+1] = elz_reg; azb[k+1] = azb_reg;
            ax_[k+1] = ax_reg; ay_[k+1] = ay_reg; bx_[k+1] = bx_reg; by_[k+1] = by_reg;
            az_[k+1] = az_reg; bz_[k+1] = bz_reg;
        end
    end

    // ---------------- round to Q3.13 and clamp
    logic signed [24:0] aa, ea;
    logic [24:0]        am, em;
    logic signed [17:0] ar, er;
    logic signed [15:0] azo, elo;
    always_comb begin
        aa = azz[CordicSteps] ? 25'(azb[CordicSteps])
             : 25'(azb[CordicSteps]) + 25'(az_[CordicSteps]);
        ea = elz[CordicSteps] ? 25'sd0 : 25'(bz_[CordicSteps]);
        am = aa[24] ? 25'(-aa) : aa;
        em = ea[24] ? 25'(-ea) : ea;
        ar = $signed({1'b0, 17'((am + 25'd64) >> 7)});
        er = $signed({1'b0, 17'((em + 25'd64) >> 7)});
        if (aa[24]) ar = -ar;
        if (ea[24]) er = -er;
        if (ar > 18'(AZ_LIMIT)) azo = AZ_LIMIT;
        else if (ar < -18'(AZ_LIMIT)) azo = -AZ_LIMIT;
        else azo = ar[15:0];
        if (er > 18'(EL_LIMIT)) elo = EL_LIMIT;
        else if (er < -18'(EL_LIMIT)) elo = -EL_LIMIT;
        else elo = er[15:0];
        if (!cok[CordicSteps]) begin
            azo = '0; elo = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_tvalid <= 1'b0;
        else if (adv) m_tvalid <= cv[CordicSteps];
        if (adv) begin
            m_tdata <= {cok[CordicSteps], elo[14:0], azo};
            m_tlast <= cl[CordicSteps];
        end
    end

endmodule
`default_nettype wire

// File: hdl/prae_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prae_checker
// Port-level checks of the pixel ray angle pipeline.
// ----------------------------------------------------------------------------
module prae_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [31:0] m_tdata,
    input wire        m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output");
    a_inval: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[31] |-> m_tdata[30:0] == 31'd0)
        else $error("invalid angle with nonzero fields");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
endmodule

bind pixel_ray_azimuth_elevation prae_checker u_prae_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire
